// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every rising clk edge, switched off while reset is asserted
`define SEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising clk edge, reset included
`define SEC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SEC_ASSERT(lbl, prop, msg)
`define SEC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/sec_pkg.sv =====
// ----------------------------------------------------------------------------
// sec_pkg
// Widths, register map, event codes and the event bundle type.
// ----------------------------------------------------------------------------
package sec_pkg;

    // Sample widths
    localparam int LIGHT_WIDTH    = 12;
    localparam int DISTANCE_WIDTH = 10;
    localparam int LHYST_WIDTH    = LIGHT_WIDTH - 1;
    localparam int HOUR_WIDTH     = 5;
    localparam int CFG_DATA_WIDTH = (LIGHT_WIDTH > DISTANCE_WIDTH) ? LIGHT_WIDTH
                                                                   : DISTANCE_WIDTH;

    // Register map
    typedef enum logic [1:0] {
        REG_DARK_THRESHOLD   = 2'd0,
        REG_LIGHT_HYSTERESIS = 2'd1,
        REG_NEAR_LIMIT       = 2'd2,
        REG_DIST_HYSTERESIS  = 2'd3
    } cfg_reg_t;

    localparam logic [LIGHT_WIDTH-1:0]    DARK_THRESHOLD_RST = LIGHT_WIDTH'(2048);
    localparam logic [LHYST_WIDTH-1:0]    LIGHT_HYST_RST     = LHYST_WIDTH'(100);
    localparam logic [DISTANCE_WIDTH-1:0] NEAR_LIMIT_RST     = DISTANCE_WIDTH'(50);
    localparam logic [DISTANCE_WIDTH-1:0] DIST_HYST_RST      = DISTANCE_WIDTH'(10);

    // Event codes
    typedef enum logic [3:0] {
        EV_PRESS       = 4'd0,
        EV_RELEASE     = 4'd1,
        EV_BRIGHT      = 4'd2,
        EV_DARK        = 4'd3,
        EV_LEAVING     = 4'd4,
        EV_APPROACHING = 4'd5,
        EV_MORNING     = 4'd6,
        EV_AFTERNOON   = 4'd7,
        EV_EVENING     = 4'd8,
        EV_NIGHT       = 4'd9
    } event_code_t;

    // Day periods
    localparam logic [2:0] PERIOD_MORNING   = 3'd0;
    localparam logic [2:0] PERIOD_AFTERNOON = 3'd1;
    localparam logic [2:0] PERIOD_EVENING   = 3'd2;
    localparam logic [2:0] PERIOD_NIGHT     = 3'd3;
    localparam logic [2:0] PERIOD_UNKNOWN   = 3'd4;

    localparam logic [HOUR_WIDTH-1:0] HOUR_MORNING   = HOUR_WIDTH'(7);
    localparam logic [HOUR_WIDTH-1:0] HOUR_AFTERNOON = HOUR_WIDTH'(12);
    localparam logic [HOUR_WIDTH-1:0] HOUR_EVENING   = HOUR_WIDTH'(17);
    localparam logic [HOUR_WIDTH-1:0] HOUR_NIGHT     = HOUR_WIDTH'(22);

    // Events produced by one poll, in emission order
    localparam int EVENTS_MAX = 4;
    localparam int EV_IDX_W   = $clog2(EVENTS_MAX);

    typedef struct packed {
        logic [EV_IDX_W-1:0]            last_idx;
        event_code_t [EVENTS_MAX-1:0]   codes;
    } bundle_t;

    // Queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== src/sec_if.sv =====
// ----------------------------------------------------------------------------
// sec_if
// Valid/ready channels for sensor polls and classified events.
// ----------------------------------------------------------------------------
interface sec_poll_if;
    logic                                valid;
    logic                                ready;
    logic                                touched;
    logic [sec_pkg::LIGHT_WIDTH-1:0]     light_level;
    logic [sec_pkg::DISTANCE_WIDTH-1:0]  distance_cm;
    logic                                time_valid;
    logic [sec_pkg::HOUR_WIDTH-1:0]      hour;

    modport source (output valid, touched, light_level, distance_cm, time_valid, hour,
                    input ready);
    modport sink (input valid, touched, light_level, distance_cm, time_valid, hour,
                  output ready);
endinterface

interface sec_event_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_code;
    logic        last_event;

    modport source (output valid, event_code, last_event, input ready);
    modport sink (input valid, event_code, last_event, output ready);
endinterface

// ===== src/sec_front.sv =====
// ----------------------------------------------------------------------------
// sec_front
// Accepts polls, holds the config and sensor state, builds the event bundle.
// ----------------------------------------------------------------------------
module sec_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    sec_poll_if.sink                             poll,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [sec_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  sec_pkg::queue_status_t               q_status,
    output logic                                 push,
    output sec_pkg::bundle_t                     bundle
);

    localparam int LSUM_W = sec_pkg::LIGHT_WIDTH + 1;
    localparam int DSUM_W = sec_pkg::DISTANCE_WIDTH + 1;

    logic [sec_pkg::LIGHT_WIDTH-1:0]    dark_threshold_reg;
    logic [sec_pkg::LHYST_WIDTH-1:0]    light_hysteresis_reg;
    logic [sec_pkg::DISTANCE_WIDTH-1:0] near_limit_reg;
    logic [sec_pkg::DISTANCE_WIDTH-1:0] dist_hysteresis_reg;

    logic       prev_touch_reg, prev_touch_next;
    logic       ambient_dark_reg, ambient_dark_next;
    logic       user_near_reg, user_near_next;
    logic [2:0] day_period_reg, day_period_next;

    logic                              accept;
    logic [LSUM_W-1:0]                 light_lo_sum;
    logic [LSUM_W-1:0]                 light_hi_sum;
    logic [DSUM_W-1:0]                 dist_far_sum;
    logic [2:0]                        period;
    logic [2:0]                        n_events;
    sec_pkg::event_code_t [sec_pkg::EVENTS_MAX-1:0] codes;

    assign poll.ready = !q_status.full;
    assign accept     = poll.valid && poll.ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_threshold_reg   <= sec_pkg::DARK_THRESHOLD_RST;
            light_hysteresis_reg <= sec_pkg::LIGHT_HYST_RST;
            near_limit_reg       <= sec_pkg::NEAR_LIMIT_RST;
            dist_hysteresis_reg  <= sec_pkg::DIST_HYST_RST;
        end
        else if (cfg_we)
        begin
            case (sec_pkg::cfg_reg_t'(cfg_index))
                sec_pkg::REG_DARK_THRESHOLD:
                    dark_threshold_reg <= cfg_data[sec_pkg::LIGHT_WIDTH-1:0];
                sec_pkg::REG_LIGHT_HYSTERESIS:
                    light_hysteresis_reg <= cfg_data[sec_pkg::LHYST_WIDTH-1:0];
                sec_pkg::REG_NEAR_LIMIT:
                    near_limit_reg <= cfg_data[sec_pkg::DISTANCE_WIDTH-1:0];
                sec_pkg::REG_DIST_HYSTERESIS:
                    dist_hysteresis_reg <= cfg_data[sec_pkg::DISTANCE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Threshold sums, one bit wider so nothing wraps.
    // light < thr - hyst is tested as light + hyst < thr.
    assign light_lo_sum = LSUM_W'(poll.light_level) + LSUM_W'(light_hysteresis_reg);
    assign light_hi_sum = LSUM_W'(dark_threshold_reg) + LSUM_W'(light_hysteresis_reg);
    assign dist_far_sum = DSUM_W'(near_limit_reg) + DSUM_W'(dist_hysteresis_reg);

    // Hour to period
    always_comb
    begin
        if (poll.hour inside {[sec_pkg::HOUR_MORNING : sec_pkg::HOUR_AFTERNOON - 1'b1]})
            period = sec_pkg::PERIOD_MORNING;
        else if (poll.hour inside {[sec_pkg::HOUR_AFTERNOON : sec_pkg::HOUR_EVENING - 1'b1]})
            period = sec_pkg::PERIOD_AFTERNOON;
        else if (poll.hour inside {[sec_pkg::HOUR_EVENING : sec_pkg::HOUR_NIGHT - 1'b1]})
            period = sec_pkg::PERIOD_EVENING;
        else
            period = sec_pkg::PERIOD_NIGHT;
    end

    // Classify: events are packed in fixed order touch, light, distance, period
    always_comb
    begin
        n_events          = '0;
        codes             = '{default: sec_pkg::EV_PRESS};
        prev_touch_next   = prev_touch_reg;
        ambient_dark_next = ambient_dark_reg;
        user_near_next    = user_near_reg;
        day_period_next   = day_period_reg;

        if (poll.touched != prev_touch_reg)
        begin
            codes[n_events[sec_pkg::EV_IDX_W-1:0]] = poll.touched ? sec_pkg::EV_PRESS
                                                                  : sec_pkg::EV_RELEASE;
            n_events        = n_events + 3'd1;
            prev_touch_next = poll.touched;
        end

        if (ambient_dark_reg)
        begin
            if (light_lo_sum < LSUM_W'(dark_threshold_reg))
            begin
                codes[n_events[sec_pkg::EV_IDX_W-1:0]] = sec_pkg::EV_BRIGHT;
                n_events          = n_events + 3'd1;
                ambient_dark_next = 1'b0;
            end
        end
        else if (LSUM_W'(poll.light_level) > light_hi_sum)
        begin
            codes[n_events[sec_pkg::EV_IDX_W-1:0]] = sec_pkg::EV_DARK;
            n_events          = n_events + 3'd1;
            ambient_dark_next = 1'b1;
        end

        // Zero distance means a lost echo
        if (poll.distance_cm != '0)
        begin
            if (user_near_reg)
            begin
                if (DSUM_W'(poll.distance_cm) > dist_far_sum)
                begin
                    codes[n_events[sec_pkg::EV_IDX_W-1:0]] = sec_pkg::EV_LEAVING;
                    n_events       = n_events + 3'd1;
                    user_near_next = 1'b0;
                end
            end
            else if (poll.distance_cm <= near_limit_reg)
            begin
                codes[n_events[sec_pkg::EV_IDX_W-1:0]] = sec_pkg::EV_APPROACHING;
                n_events       = n_events + 3'd1;
                user_near_next = 1'b1;
            end
        end

        if (poll.time_valid && (period != day_period_reg))
        begin
            case (period)
                sec_pkg::PERIOD_MORNING:
                    codes[n_events[sec_pkg::EV_IDX_W-1:0]] = sec_pkg::EV_MORNING;
                sec_pkg::PERIOD_AFTERNOON:
                    codes[n_events[sec_pkg::EV_IDX_W-1:0]] = sec_pkg::EV_AFTERNOON;
                sec_pkg::PERIOD_EVENING:
                    codes[n_events[sec_pkg::EV_IDX_W-1:0]] = sec_pkg::EV_EVENING;
                default:
                    codes[n_events[sec_pkg::EV_IDX_W-1:0]] = sec_pkg::EV_NIGHT;
            endcase
            n_events        = n_events + 3'd1;
            day_period_next = period;
        end
    end

    assign push            = accept && (n_events != '0);
    assign bundle.codes    = codes;
    assign bundle.last_idx = sec_pkg::EV_IDX_W'(n_events - 3'd1);

    // Sensor state advances on every accepted poll
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_touch_reg   <= 1'b0;
            ambient_dark_reg <= 1'b0;
            user_near_reg    <= 1'b0;
            day_period_reg   <= sec_pkg::PERIOD_UNKNOWN;
        end
        else if (accept)
        begin
            prev_touch_reg   <= prev_touch_next;
            ambient_dark_reg <= ambient_dark_next;
            user_near_reg    <= user_near_next;
            day_period_reg   <= day_period_next;
        end
    end

endmodule

// ===== src/sec_queue.sv =====
// ----------------------------------------------------------------------------
// sec_queue
// Two-entry queue of event bundles between the front and back ends.
// ----------------------------------------------------------------------------
module sec_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  sec_pkg::bundle_t        wdata,
    input  logic                    pop,
    output sec_pkg::bundle_t        rdata,
    output sec_pkg::queue_status_t  status
);

    sec_pkg::bundle_t entries [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign rdata        = entries[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= wdata;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== src/sec_back.sv =====
// ----------------------------------------------------------------------------
// sec_back
// Walks the head bundle one event per cycle into the output register, holding while events.ready is low.
// ----------------------------------------------------------------------------
module sec_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sec_pkg::bundle_t        head,
    input  sec_pkg::queue_status_t  q_status,
    output logic                    pop,
    sec_event_if.source             events
);

    logic                         valid_reg;
    logic [3:0]                   code_reg;
    logic                         last_reg;
    logic [sec_pkg::EV_IDX_W-1:0] idx_reg;

    logic out_free;
    logic load;
    logic is_last;

    assign out_free = !valid_reg || events.ready;
    assign load     = out_free && !q_status.empty;
    assign is_last  = (idx_reg == head.last_idx);
    assign pop      = load && is_last;

    // Output valid and walk index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (out_free)
        begin
            valid_reg <= !q_status.empty;
            if (load)
                idx_reg <= is_last ? '0 : idx_reg + 1'b1;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            code_reg <= head.codes[idx_reg];
            last_reg <= is_last;
        end
    end

    assign events.valid      = valid_reg;
    assign events.event_code = code_reg;
    assign events.last_event = last_reg;

endmodule

// ===== src/sensor_event_classifier_core.sv =====
// ----------------------------------------------------------------------------
// sensor_event_classifier_core
// Sensor poll classifier: touch, light, proximity and day-period events.
// ----------------------------------------------------------------------------
// Usage:
//   poll   : valid/ready sink, one transaction per sensor poll.
//   events : valid/ready source, zero to four transactions per poll, in order
//            touch, light, distance, period; last_event marks the final one.
//   cfg_*  : write-only register port, written while the block is idle.
// Path: the first event of a poll is written into the bundle queue, then loaded
//   into the output register once that register is free, and appears from there.
// Throughput: a poll is accepted every cycle while the two-entry bundle queue
//   has room; the output register drains one event per cycle while events.ready is high.
// Reset: config registers take their default values, the touch, dark and
//   near flags clear and the day period becomes unknown, so the first valid
//   hour always produces a period event. Queue and output are emptied.
// Stall: while events.ready is low the output holds, the queue fills, and
//   poll.ready drops once both queue entries are taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sensor_event_classifier_core (
    input  logic                                clk,
    input  logic                                rst_n,
    sec_poll_if.sink                            poll,
    sec_event_if.source                         events,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [sec_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic                    push;
    logic                    pop;
    sec_pkg::bundle_t        wr_bundle;
    sec_pkg::bundle_t        head_bundle;
    sec_pkg::queue_status_t  q_status;

    // Front end: accept and classify
    sec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .poll      (poll),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .bundle    (wr_bundle)
    );

    // Bundle queue
    sec_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (wr_bundle),
        .pop    (pop),
        .rdata  (head_bundle),
        .status (q_status)
    );

    // Back end: serialize events
    sec_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head_bundle),
        .q_status (q_status),
        .pop      (pop),
        .events   (events)
    );

    // Checks
    `SEC_ASSERT(a_no_push_full, push |-> !q_status.full, "bundle pushed into full queue")
    `SEC_ASSERT(a_no_pop_empty, pop |-> !q_status.empty, "bundle popped from empty queue")
    `SEC_ASSERT_ALWAYS(a_status_sane, !(q_status.full && q_status.empty),
                       "queue reports full and empty")
    `SEC_ASSERT(a_load_from_queue, $rose(events.valid) |-> $past(!q_status.empty),
                "event shown with no bundle queued")

endmodule
